// ===== hdl/telt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telt_pkg
// Types and constants shared by the timed eviction lookaside table.
// ----------------------------------------------------------------------------
package telt_pkg;

    // field widths of the data words
    localparam int OP_W     = 2;
    localparam int GROUP_W  = 16;
    localparam int PATH_W   = 32;
    localparam int HANDLE_W = 32;
    localparam int DIM_W    = 15;
    localparam int TIME_W   = 16;

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // register index, taken from paddr[2]
    localparam logic REG_LIFETIME = 1'b0;

    localparam logic [TIME_W-1:0] LIFETIME_RST = 16'd1000;

    typedef enum logic [OP_W-1:0] {
        OP_BURY      = 2'd0,
        OP_TICK      = 2'd1,
        OP_RESURRECT = 2'd2,
        OP_NOP       = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK_RD,
        S_TICK_EV,
        S_RES_RD,
        S_RES_EV,
        S_RES_WR,
        S_DONE
    } t_state;

    // one table entry as held in the memory
    typedef struct packed {
        logic [GROUP_W-1:0]  group;
        logic [PATH_W-1:0]   path;
        logic [HANDLE_W-1:0] handle;
        logic [DIM_W-1:0]    width;
        logic [DIM_W-1:0]    height;
        logic [TIME_W-1:0]   remaining;
    } t_entry;

endpackage

// ===== hdl/telt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telt_ram
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module telt_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  telt_pkg::t_entry  i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output telt_pkg::t_entry  o_rdata
);
    import telt_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/timed_eviction_lookaside_table.sv =====
`timescale 1ns / 1ps
// Bury goes from idle through the done state to the result register; tick and
// resurrect walk the held entries (resurrect up to its first match), a read
// and an evaluate state each, through the registered-read entry memory and
// one shared unit. A stalled result holds the done state. One word at a time:
// the next word is taken once the sequencer is back in idle.
// Reset (synchronous, active low) empties the table and sets lifetime to 1000.
// ----------------------------------------------------------------------------
// timed_eviction_lookaside_table
// TTL table of released images keyed by group and path id, with expiry on
// tick and remove-by-key with last-entry backfill.
// ----------------------------------------------------------------------------
module timed_eviction_lookaside_table #(
    parameter int DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [telt_pkg::OP_W-1:0]           i_opcode,
    input  logic [telt_pkg::GROUP_W-1:0]        i_group_id,
    input  logic [telt_pkg::PATH_W-1:0]         i_path_id,
    input  logic [telt_pkg::HANDLE_W-1:0]       i_image_handle,
    input  logic [telt_pkg::DIM_W-1:0]          i_image_width,
    input  logic [telt_pkg::DIM_W-1:0]          i_image_height,
    input  logic [telt_pkg::TIME_W-1:0]         i_elapsed_ms,

    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_accepted,
    output logic [telt_pkg::HANDLE_W-1:0]       o_found_handle,
    output logic [telt_pkg::DIM_W-1:0]          o_found_width,
    output logic [telt_pkg::DIM_W-1:0]          o_found_height,
    output logic [$clog2(DEPTH+1)-1:0]          o_expired_count,
    output logic [$clog2(DEPTH+1)-1:0]          o_live_count,

    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [telt_pkg::APB_AW-1:0]         paddr,
    input  logic [telt_pkg::APB_DW-1:0]         pwdata,
    output logic [telt_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);
    import telt_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    t_state r_state, n_state;

    logic [TIME_W-1:0]   r_lifetime;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_keep, n_keep;
    logic [CW-1:0]       r_exp, n_exp;
    logic [GROUP_W-1:0]  r_grp, n_grp;
    logic [PATH_W-1:0]   r_path, n_path;
    logic [TIME_W-1:0]   r_elapsed, n_elapsed;

    logic                r_res_acc, n_res_acc;
    logic [HANDLE_W-1:0] r_res_handle, n_res_handle;
    logic [DIM_W-1:0]    r_res_w, n_res_w;
    logic [DIM_W-1:0]    r_res_h, n_res_h;
    logic [CW-1:0]       r_res_exp, n_res_exp;

    logic                r_out_valid, n_out_valid;
    logic                r_out_acc, n_out_acc;
    logic [HANDLE_W-1:0] r_out_handle, n_out_handle;
    logic [DIM_W-1:0]    r_out_w, n_out_w;
    logic [DIM_W-1:0]    r_out_h, n_out_h;
    logic [CW-1:0]       r_out_exp, n_out_exp;
    logic [CW-1:0]       r_out_live, n_out_live;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    t_entry              mem_wdata;
    logic [AW-1:0]       mem_raddr;
    t_entry              rd_data;
    t_entry              aged;

    logic                in_fire;
    logic                out_free;
    logic                cfg_wr;
    logic                bury_ok;
    logic                res_ok;
    logic [CW-1:0]       idx_inc;
    logic [CW-1:0]       last_idx;
    logic                last_hit;
    logic [TIME_W:0]     sub;
    logic                survive;
    logic                key_match;

    // handshakes
    assign o_in_stall = !i_rst_n || (r_state != S_IDLE);
    assign in_fire    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_LIFETIME);
    assign prdata = (paddr[2] == REG_LIFETIME) ?
                    {{(APB_DW-TIME_W){1'b0}}, r_lifetime} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lifetime <= LIFETIME_RST;
        end else if (cfg_wr) begin
            r_lifetime <= pwdata[TIME_W-1:0];
        end
    end

    // admission checks
    assign bury_ok = (i_path_id != '0) && (r_lifetime != '0) && (r_count != FULL);
    assign res_ok  = (i_path_id != '0) && (r_lifetime != '0) && (r_count != '0);

    // walk position
    assign idx_inc  = r_idx + CW'(1);
    assign last_idx = r_count - CW'(1);
    assign last_hit = (idx_inc == r_count);

    // shared unit: age subtract doubles as the expiry compare; key compare
    assign sub       = {1'b0, rd_data.remaining} - {1'b0, r_elapsed};
    assign survive   = !sub[TIME_W] && (sub[TIME_W-1:0] != '0);
    assign key_match = (rd_data.group == r_grp) && (rd_data.path == r_path);

    always_comb begin
        aged           = rd_data;
        aged.remaining = sub[TIME_W-1:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    unique case (t_opcode'(i_opcode))
                        OP_TICK:      n_state = (r_count == '0) ? S_DONE : S_TICK_RD;
                        OP_RESURRECT: n_state = res_ok ? S_RES_RD : S_DONE;
                        OP_BURY,
                        OP_NOP:       n_state = S_DONE;
                        default:      n_state = S_DONE;
                    endcase
                end
            end
            S_TICK_RD: n_state = S_TICK_EV;
            S_TICK_EV: n_state = last_hit ? S_DONE : S_TICK_RD;
            S_RES_RD:  n_state = S_RES_EV;
            S_RES_EV: begin
                if (key_match) begin
                    n_state = last_hit ? S_DONE : S_RES_WR;
                end else begin
                    n_state = last_hit ? S_DONE : S_RES_RD;
                end
            end
            S_RES_WR:  n_state = S_DONE;
            S_DONE:    n_state = out_free ? S_IDLE : S_DONE;
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_count      = r_count;
        n_idx        = r_idx;
        n_keep       = r_keep;
        n_exp        = r_exp;
        n_grp        = r_grp;
        n_path       = r_path;
        n_elapsed    = r_elapsed;
        n_res_acc    = r_res_acc;
        n_res_handle = r_res_handle;
        n_res_w      = r_res_w;
        n_res_h      = r_res_h;
        n_res_exp    = r_res_exp;
        mem_we       = 1'b0;
        mem_waddr    = r_idx[AW-1:0];
        mem_wdata    = rd_data;
        mem_raddr    = r_idx[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_grp        = i_group_id;
                    n_path       = i_path_id;
                    n_elapsed    = i_elapsed_ms;
                    n_idx        = '0;
                    n_keep       = '0;
                    n_exp        = '0;
                    n_res_acc    = 1'b0;
                    n_res_handle = '0;
                    n_res_w      = '0;
                    n_res_h      = '0;
                    n_res_exp    = '0;
                    if (t_opcode'(i_opcode) == OP_TICK) begin
                        n_res_acc = 1'b1;
                    end
                    // append at the end of the table
                    if ((t_opcode'(i_opcode) == OP_BURY) && bury_ok) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_count[AW-1:0];
                        mem_wdata = '{group:     i_group_id,
                                      path:      i_path_id,
                                      handle:    i_image_handle,
                                      width:     i_image_width,
                                      height:    i_image_height,
                                      remaining: r_lifetime};
                        n_count   = r_count + CW'(1);
                        n_res_acc = 1'b1;
                    end
                end
            end
            S_TICK_EV: begin
                // survivors compact down to the keep position
                if (survive) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_keep[AW-1:0];
                    mem_wdata = aged;
                    n_keep    = r_keep + CW'(1);
                end else begin
                    n_exp = r_exp + CW'(1);
                end
                n_idx = idx_inc;
                if (last_hit) begin
                    n_count   = n_keep;
                    n_res_exp = n_exp;
                end
            end
            S_RES_EV: begin
                // fetch the last entry in case it backfills this slot
                mem_raddr = last_idx[AW-1:0];
                if (key_match) begin
                    n_res_acc    = 1'b1;
                    n_res_handle = rd_data.handle;
                    n_res_w      = rd_data.width;
                    n_res_h      = rd_data.height;
                    if (last_hit) begin
                        n_count = last_idx;
                    end
                end else begin
                    n_idx = idx_inc;
                end
            end
            S_RES_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[AW-1:0];
                mem_wdata = rd_data;
                n_count   = last_idx;
            end
            S_TICK_RD,
            S_RES_RD,
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // result register
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_acc    = r_out_acc;
        n_out_handle = r_out_handle;
        n_out_w      = r_out_w;
        n_out_h      = r_out_h;
        n_out_exp    = r_out_exp;
        n_out_live   = r_out_live;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if ((r_state == S_DONE) && out_free) begin
            n_out_valid  = 1'b1;
            n_out_acc    = r_res_acc;
            n_out_handle = r_res_handle;
            n_out_w      = r_res_w;
            n_out_h      = r_res_h;
            n_out_exp    = r_res_exp;
            n_out_live   = r_count;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_keep       <= n_keep;
        r_exp        <= n_exp;
        r_grp        <= n_grp;
        r_path       <= n_path;
        r_elapsed    <= n_elapsed;
        r_res_acc    <= n_res_acc;
        r_res_handle <= n_res_handle;
        r_res_w      <= n_res_w;
        r_res_h      <= n_res_h;
        r_res_exp    <= n_res_exp;
        r_out_acc    <= n_out_acc;
        r_out_handle <= n_out_handle;
        r_out_w      <= n_out_w;
        r_out_h      <= n_out_h;
        r_out_exp    <= n_out_exp;
        r_out_live   <= n_out_live;
    end

    // entry memory
    telt_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rd_data)
    );

    assign o_out_valid     = r_out_valid;
    assign o_accepted      = r_out_acc;
    assign o_found_handle  = r_out_handle;
    assign o_found_width   = r_out_w;
    assign o_found_height  = r_out_h;
    assign o_expired_count = r_out_exp;
    assign o_live_count    = r_out_live;

endmodule

// ===== hdl/telt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telt_checker
// Port-level checks for the timed eviction lookaside table, bound to the top.
// ----------------------------------------------------------------------------
module telt_checker #(
    parameter int DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          o_in_stall,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  logic                          o_accepted,
    input  logic [telt_pkg::HANDLE_W-1:0] o_found_handle,
    input  logic [telt_pkg::DIM_W-1:0]    o_found_width,
    input  logic [telt_pkg::DIM_W-1:0]    o_found_height,
    input  logic [$clog2(DEPTH+1)-1:0]    o_expired_count,
    input  logic [$clog2(DEPTH+1)-1:0]    o_live_count
);
    import telt_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_accepted) &&
        $stable(o_found_handle) && $stable(o_live_count) && $stable(o_expired_count))
        else $error("stalled result word changed");

    // one word in flight: taking a word closes the input
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input open right after accepting a word");

    // table never reports more than it can hold
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_live_count <= CW'(DEPTH))
        else $error("live count above table depth");

    // expiries come only from a tick, which is always accepted
    a_exp_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_expired_count != '0) |-> o_accepted &&
        (o_found_handle == '0) && (o_found_width == '0) && (o_found_height == '0))
        else $error("expired count on a non-tick result");

    // found data only on a successful resurrect
    a_found_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_found_handle != '0) || (o_found_width != '0) ||
        (o_found_height != '0)) |-> o_accepted && (o_expired_count == '0))
        else $error("found data without an accepted resurrect");

endmodule

bind timed_eviction_lookaside_table telt_checker #(
    .DEPTH (DEPTH)
) u_telt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_accepted      (o_accepted),
    .o_found_handle  (o_found_handle),
    .o_found_width   (o_found_width),
    .o_found_height  (o_found_height),
    .o_expired_count (o_expired_count),
    .o_live_count    (o_live_count)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the timed eviction lookaside table. A cycle-free
// model of the table (entries, lifetimes, expiry, backfill on resurrect)
// predicts one result word per accepted input word. A monitor compares every
// result word field by field against the oldest prediction. Stimulus is a
// directed set of corner cases followed by randomized traffic under several
// lifetimes and idle/stall mixes, including a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import telt_pkg::*;

    localparam int TBL_DEPTH     = 16;
    localparam int CNT_W         = $clog2(TBL_DEPTH + 1);
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 2 * TBL_DEPTH + 4;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_REPORTS   = 40;
    localparam logic [APB_AW-1:0] ADDR_LIFETIME = {REG_LIFETIME, 2'b00};

    // one input word
    typedef struct {
        t_opcode             op;
        logic [GROUP_W-1:0]  group;
        logic [PATH_W-1:0]   path;
        logic [HANDLE_W-1:0] handle;
        logic [DIM_W-1:0]    width;
        logic [DIM_W-1:0]    height;
        logic [TIME_W-1:0]   elapsed;
    } t_request;

    // one result word
    typedef struct {
        logic                accepted;
        logic [HANDLE_W-1:0] handle;
        logic [DIM_W-1:0]    width;
        logic [DIM_W-1:0]    height;
        logic [CNT_W-1:0]    expired;
        logic [CNT_W-1:0]    live;
    } t_reply;

    // one held entry of the shadow table
    typedef struct {
        logic [GROUP_W-1:0]  group;
        logic [PATH_W-1:0]   path;
        logic [HANDLE_W-1:0] handle;
        logic [DIM_W-1:0]    width;
        logic [DIM_W-1:0]    height;
        logic [TIME_W-1:0]   remaining;
    } t_slot;

    // DUT signals
    logic                 i_clk;
    logic                 i_rst_n        = 1'b0;
    logic                 i_in_valid     = 1'b0;
    logic                 o_in_stall;
    logic [OP_W-1:0]      i_opcode       = '0;
    logic [GROUP_W-1:0]   i_group_id     = '0;
    logic [PATH_W-1:0]    i_path_id      = '0;
    logic [HANDLE_W-1:0]  i_image_handle = '0;
    logic [DIM_W-1:0]     i_image_width  = '0;
    logic [DIM_W-1:0]     i_image_height = '0;
    logic [TIME_W-1:0]    i_elapsed_ms   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall    = 1'b0;
    logic                 o_accepted;
    logic [HANDLE_W-1:0]  o_found_handle;
    logic [DIM_W-1:0]     o_found_width;
    logic [DIM_W-1:0]     o_found_height;
    logic [CNT_W-1:0]     o_expired_count;
    logic [CNT_W-1:0]     o_live_count;
    logic                 psel           = 1'b0;
    logic                 penable        = 1'b0;
    logic                 pwrite         = 1'b0;
    logic [APB_AW-1:0]    paddr          = '0;
    logic [APB_DW-1:0]    pwdata         = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    // shadow table and prediction queue
    t_slot                cache_slot [TBL_DEPTH];
    int                   cache_count   = 0;
    logic [TIME_W-1:0]    cur_lifetime  = LIFETIME_RST;
    t_reply               replies_due[$];

    // idle/stall control
    int                   snd_idle_pct  = 0;
    int                   rcv_idle_pct  = 0;
    int                   hold_token    = 0;
    int                   hold_seen     = 0;
    int                   hold_left     = 0;

    // bookkeeping
    int                   mismatches    = 0;
    int                   cycle_count   = 0;
    int                   n_words       = 0;
    int                   n_checked     = 0;
    int                   n_bury        = 0;
    int                   n_stored      = 0;
    int                   n_refused_full = 0;
    int                   n_tick        = 0;
    int                   n_expired     = 0;
    int                   n_resurrect   = 0;
    int                   n_hits        = 0;
    int                   n_cfg         = 0;
    int                   peak_count    = 0;

    timed_eviction_lookaside_table #(
        .DEPTH(TBL_DEPTH)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_group_id      (i_group_id),
        .i_path_id       (i_path_id),
        .i_image_handle  (i_image_handle),
        .i_image_width   (i_image_width),
        .i_image_height  (i_image_height),
        .i_elapsed_ms    (i_elapsed_ms),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_accepted      (o_accepted),
        .o_found_handle  (o_found_handle),
        .o_found_width   (o_found_width),
        .o_found_height  (o_found_height),
        .o_expired_count (o_expired_count),
        .o_live_count    (o_live_count),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("cycle limit of %0d reached with %0d results outstanding",
                     CYCLE_LIMIT, replies_due.size());
            $display("timed_eviction_lookaside_table regression: fail");
            $finish;
        end
    end

    // result-side stall: random, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_REPORTS)
            $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                                      n_checked, name, got, want));
    endtask

    // ------------------------------------------------------------------
    // predictor: applies one word to the shadow table, returns the result
    // ------------------------------------------------------------------
    function automatic t_reply apply_to_cache(input t_request rq);
        t_reply rp;
        int     keep;
        bit     hit;
        rp = '{default: '0};
        n_words++;
        case (rq.op)
            OP_BURY: begin
                n_bury++;
                if (rq.path != '0 && cur_lifetime != '0 && cache_count < TBL_DEPTH) begin
                    cache_slot[cache_count] = '{rq.group, rq.path, rq.handle,
                                                rq.width, rq.height, cur_lifetime};
                    cache_count++;
                    rp.accepted = 1'b1;
                    n_stored++;
                end else if (rq.path != '0 && cur_lifetime != '0) begin
                    n_refused_full++;
                end
            end
            OP_TICK: begin
                // age everything, compact survivors in order
                n_tick++;
                keep = 0;
                for (int i = 0; i < cache_count; i++) begin
                    if (cache_slot[i].remaining > rq.elapsed) begin
                        cache_slot[i].remaining = cache_slot[i].remaining - rq.elapsed;
                        cache_slot[keep] = cache_slot[i];
                        keep++;
                    end else begin
                        rp.expired++;
                    end
                end
                n_expired += cache_count - keep;
                cache_count = keep;
                rp.accepted = 1'b1;
            end
            OP_RESURRECT: begin
                // first match wins, last entry backfills the hole
                n_resurrect++;
                hit = 1'b0;
                if (rq.path != '0 && cur_lifetime != '0) begin
                    for (int i = 0; i < cache_count; i++) begin
                        if (!hit && cache_slot[i].group == rq.group &&
                            cache_slot[i].path == rq.path) begin
                            hit = 1'b1;
                            rp.accepted = 1'b1;
                            rp.handle = cache_slot[i].handle;
                            rp.width  = cache_slot[i].width;
                            rp.height = cache_slot[i].height;
                            cache_slot[i] = cache_slot[cache_count - 1];
                            cache_count--;
                            n_hits++;
                        end
                    end
                end
            end
            default: ;
        endcase
        rp.live = CNT_W'(cache_count);
        if (cache_count > peak_count)
            peak_count = cache_count;
        return rp;
    endfunction

    // ------------------------------------------------------------------
    // result monitor
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_reply due;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (replies_due.size() == 0) begin
                report_mismatch($sformatf("result word with none outstanding (live %0d)",
                                          o_live_count));
            end else begin
                due = replies_due.pop_front();
                check_field("accepted", 32'(o_accepted), 32'(due.accepted));
                check_field("found_handle", o_found_handle, due.handle);
                check_field("found_width", 32'(o_found_width), 32'(due.width));
                check_field("found_height", 32'(o_found_height), 32'(due.height));
                check_field("expired_count", 32'(o_expired_count), 32'(due.expired));
                check_field("live_count", 32'(o_live_count), 32'(due.live));
            end
            n_checked++;
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    // called and returns at a falling edge; valid stays up for back-to-back
    task automatic send_word(input t_request rq);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_opcode       <= rq.op;
        i_group_id     <= rq.group;
        i_path_id      <= rq.path;
        i_image_handle <= rq.handle;
        i_image_width  <= rq.width;
        i_image_height <= rq.height;
        i_elapsed_ms   <= rq.elapsed;
        i_in_valid     <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        replies_due.push_back(apply_to_cache(rq));
        @(negedge i_clk);
    endtask

    // sender pauses until every result is back, then lets the block settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // register write: setup then access, only with the block idle
    task automatic set_lifetime(input logic [TIME_W-1:0] value);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_LIFETIME;
        pwdata  <= {{(APB_DW-TIME_W){1'b0}}, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        cur_lifetime = value;
        n_cfg++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic t_request make_req(input t_opcode op, input logic [GROUP_W-1:0] g,
                                          input logic [PATH_W-1:0] p,
                                          input logic [HANDLE_W-1:0] h,
                                          input logic [DIM_W-1:0] w,
                                          input logic [DIM_W-1:0] ht,
                                          input logic [TIME_W-1:0] el);
        t_request rq;
        rq = '{op, g, p, h, w, ht, el};
        return rq;
    endfunction

    // random word: mostly keys that are held or collide, some noise
    function automatic t_request random_request();
        t_request rq;
        int       pick;
        int       sel;
        rq.group   = 16'($urandom);
        rq.path    = $urandom;
        rq.handle  = $urandom;
        rq.width   = 15'($urandom_range(0, 16384));
        rq.height  = 15'($urandom_range(0, 16384));
        rq.elapsed = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 42)
            rq.op = OP_BURY;
        else if (pick < 67)
            rq.op = OP_TICK;
        else if (pick < 95)
            rq.op = OP_RESURRECT;
        else
            rq.op = OP_NOP;

        // key choice
        sel = $urandom_range(99);
        if (rq.op == OP_RESURRECT && cache_count > 0 && sel < 55) begin
            pick = $urandom_range(cache_count - 1);
            rq.group = cache_slot[pick].group;
            rq.path  = cache_slot[pick].path;
        end else if (sel < 85) begin
            case ($urandom_range(3))
                0: rq.group = 16'h0000;
                1: rq.group = 16'h0001;
                2: rq.group = 16'hFFFF;
                default: ;
            endcase
            case ($urandom_range(3))
                0: rq.path = 32'h0000_0001;
                1: rq.path = 32'h0000_0002;
                2: rq.path = 32'hFFFF_FFFF;
                default: rq.path = {28'h0, 4'($urandom_range(15))} + 32'd1;
            endcase
        end else if (sel < 91) begin
            rq.path = '0;
        end

        // tick: mostly small steps, sometimes exact remaining or extremes
        if (rq.op == OP_TICK) begin
            sel = $urandom_range(99);
            if (sel < 8)
                rq.elapsed = '0;
            else if (sel < 25 && cache_count > 0)
                rq.elapsed = cache_slot[$urandom_range(cache_count - 1)].remaining;
            else if (sel < 30)
                rq.elapsed = 16'hFFFF;
            else if (sel >= 40)
                rq.elapsed = 16'($urandom_range(0, cur_lifetime / 6 + 1));
        end
        return rq;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // reset lifetime is 1000: survives a 999 tick, dies on the next 1
    task automatic test_reset_lifetime();
        send_word(make_req(OP_BURY, 16'd1, 32'd10, 32'h11, 15'd1, 15'd1, 16'd0));
        send_word(make_req(OP_TICK, 16'd0, 32'd0, 32'd0, 15'd0, 15'd0, 16'd999));
        send_word(make_req(OP_TICK, 16'd0, 32'd0, 32'd0, 15'd0, 15'd0, 16'd1));
    endtask

    // empty path, misses, duplicate keys, backfill, extremes, unused opcode
    task automatic test_special_cases();
        send_word(make_req(OP_NOP, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           15'd16384, 15'd16384, 16'hFFFF));
        send_word(make_req(OP_BURY, 16'd3, 32'd0, 32'h1234, 15'd5, 15'd6, 16'd0));
        send_word(make_req(OP_RESURRECT, 16'd3, 32'd0, 32'd0, 15'd0, 15'd0, 16'd0));
        send_word(make_req(OP_RESURRECT, 16'd1, 32'd10, 32'd0, 15'd0, 15'd0, 16'd0));
        send_word(make_req(OP_BURY, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           15'd16384, 15'd16384, 16'd0));
        send_word(make_req(OP_BURY, 16'h0000, 32'd1, 32'd0, 15'd0, 15'd0, 16'd0));
        send_word(make_req(OP_BURY, 16'hFFFF, 32'hFFFF_FFFF, 32'h5A5A_A5A5,
                           15'd16383, 15'd16383, 16'd0));
        send_word(make_req(OP_BURY, 16'd7, 32'd7, 32'h7777, 15'd7, 15'd7, 16'd0));
        send_word(make_req(OP_RESURRECT, 16'hFFFF, 32'hFFFF_FFFF, 32'd0, 15'd0, 15'd0,
                           16'd0));
        send_word(make_req(OP_RESURRECT, 16'hFFFF, 32'hFFFF_FFFF, 32'd0, 15'd0, 15'd0,
                           16'd0));
        send_word(make_req(OP_RESURRECT, 16'h0000, 32'hFFFF_FFFF, 32'd0, 15'd0, 15'd0,
                           16'd0));
        send_word(make_req(OP_TICK, 16'd0, 32'd0, 32'd0, 15'd0, 15'd0, 16'd0));
        send_word(make_req(OP_TICK, 16'd0, 32'd0, 32'd0, 15'd0, 15'd0, 16'hFFFF));
    endtask

    // lifetime 0 disables bury/resurrect but ticks still age; held entries
    // keep their own remaining time across a lifetime change
    task automatic test_lifetime_change();
        set_lifetime(16'hFFFF);
        send_word(make_req(OP_BURY, 16'd9, 32'd9, 32'h9999, 15'd9, 15'd9, 16'd0));
        set_lifetime(16'd0);
        send_word(make_req(OP_BURY, 16'd8, 32'd8, 32'h8888, 15'd8, 15'd8, 16'd0));
        send_word(make_req(OP_RESURRECT, 16'd9, 32'd9, 32'd0, 15'd0, 15'd0, 16'd0));
        send_word(make_req(OP_TICK, 16'd0, 32'd0, 32'd0, 15'd0, 15'd0, 16'd100));
        set_lifetime(16'd1);
        send_word(make_req(OP_BURY, 16'd8, 32'd8, 32'h8888, 15'd8, 15'd8, 16'd0));
        send_word(make_req(OP_TICK, 16'd0, 32'd0, 32'd0, 15'd0, 15'd0, 16'd0));
        send_word(make_req(OP_TICK, 16'd0, 32'd0, 32'd0, 15'd0, 15'd0, 16'd1));
        send_word(make_req(OP_RESURRECT, 16'd9, 32'd9, 32'd0, 15'd0, 15'd0, 16'd0));
    endtask

    // fill to DEPTH, one bury past full is refused, then flush
    task automatic test_full_table();
        set_lifetime(16'd500);
        send_word(make_req(OP_TICK, 16'd0, 32'd0, 32'd0, 15'd0, 15'd0, 16'hFFFF));
        repeat (TBL_DEPTH + 1)
            send_word(make_req(OP_BURY, 16'($urandom), $urandom | 32'd1, $urandom,
                               15'($urandom_range(0, 16384)),
                               15'($urandom_range(0, 16384)), 16'd0));
        send_word(make_req(OP_TICK, 16'd0, 32'd0, 32'd0, 15'd0, 15'd0, 16'hFFFF));
    endtask

    // random traffic under one lifetime and one idle/stall mix
    task automatic test_random_traffic(input int n_items, input int snd_pct,
                                       input int rcv_pct, input logic [TIME_W-1:0] life,
                                       input bit with_pressure);
        set_lifetime(life);
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        for (int k = 0; k < n_items; k++) begin
            // receiver goes quiet while words keep coming
            if (with_pressure && k == n_items / 3)
                hold_token++;
            // sender waits for the pipe to empty, then resumes
            if (with_pressure && k == (2 * n_items) / 3)
                wait_idle();
            send_word(random_request());
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_lifetime();
        test_special_cases();
        test_lifetime_change();
        test_full_table();
        test_random_traffic(130, 20, 73, 16'($urandom_range(200, 3000)), 1'b1);
        test_random_traffic(120, 73, 20, 16'hFFFF, 1'b0);
        test_random_traffic(40, 0, 0, 16'd1, 1'b0);
        test_random_traffic(110, 0, 0, 16'($urandom_range(1, 65535)), 1'b0);

        wait_idle();

        $display("covered %0d words: %0d bury (%0d stored, %0d refused on full),",
                 n_words, n_bury, n_stored, n_refused_full);
        $display("  %0d tick (%0d expired), %0d resurrect (%0d hits)",
                 n_tick, n_expired, n_resurrect, n_hits);
        $display("%0d results checked, %0d lifetime writes, peak occupancy %0d,",
                 n_checked, n_cfg, peak_count);
        $display("  %0d mismatches", mismatches);
        if (mismatches == 0) begin
            $display("timed_eviction_lookaside_table regression: pass");
        end else begin
            $display("timed_eviction_lookaside_table regression: fail");
        end
        $finish;
    end

endmodule

// ===== timed_eviction_lookaside_table.f =====
hdl/telt_pkg.sv
hdl/telt_ram.sv
hdl/timed_eviction_lookaside_table.sv
hdl/telt_checker.sv
tb/sv/tb_top.sv
